>>> rtl/cfc_pkg.sv
`default_nettype none

package cfc_pkg;

  // Default configuration of the classifier
  localparam int unsigned PLANE_COUNT_DEF = 6;
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned NORMAL_FRAC_DEF = 14;

  // Fixed register and plane field widths
  localparam int unsigned PLANE_W = 64;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned AXES    = 3;

  // Plane register layout: nx in the low half-word, offset d in the top one
  typedef struct packed {
    logic signed [NORM_W-1:0] d;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  // Containment codes on the result beat
  typedef enum logic [1:0] {
    CLS_DISJOINT   = 2'd0,
    CLS_INTERSECTS = 2'd1,
    CLS_CONTAINED  = 2'd2
  } cls_e;

  // Bits needed to index n registers, at least one
  function automatic int unsigned idx_width(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Signed distance width: three products plus an offset scaled by up to 2^15
  function automatic int unsigned dist_width(input int unsigned coord_w);
    return NORM_W + ((coord_w > NORM_W - 1) ? coord_w : NORM_W - 1) + 2;
  endfunction

endpackage

`default_nettype wire

>>> rtl/capsule_frustum_classify.sv
// Capsule against view-frustum classifier.
// Program the plane registers over the APB port first: plane i sits at byte
// address 8*i, 64 bits: nx [15:0], ny [31:16], nz [47:32] as Q1.14 and the
// offset d [63:48] in coordinate units. Writes take setup and access cycles;
// pready is tied high. Write planes only while no beat is in flight.
// Input channel: one capsule per beat (two axis endpoints and a radius),
// taken when in_valid_i is high and in_stall_o is low. Output channel: one
// containment code per beat (0 disjoint, 1 intersects, 2 contained), taken
// when out_valid_o is high and out_stall_i is low.
// Four register stages: products, distance sums, per-plane tests, merge. A
// result is offered from the merge stage, and a new capsule can be taken every
// cycle while in_stall_o is low; the rate is one beat per cycle, set by the
// per-plane multiplier lanes that work on a fresh capsule each cycle.
// While out_stall_i is high the pipeline fills its empty stages and then
// raises in_stall_o; no beat is dropped or repeated.
// Reset clears the pipeline valid bits and all plane registers to zero.
`default_nettype none

module capsule_frustum_classify #(
  parameter  int unsigned PLANE_COUNT      = cfc_pkg::PLANE_COUNT_DEF,
  parameter  int unsigned COORD_WIDTH      = cfc_pkg::COORD_WIDTH_DEF,
  parameter  int unsigned NORMAL_FRAC_BITS = cfc_pkg::NORMAL_FRAC_DEF,
  localparam int unsigned ADDR_W           = cfc_pkg::idx_width(PLANE_COUNT) + 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [cfc_pkg::PLANE_W-1:0]   pwdata,
  output logic      [cfc_pkg::PLANE_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_z_i,
  input  wire logic        [COORD_WIDTH-2:0] capsule_radius_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic             [1:0]             containment_o
);
  import cfc_pkg::*;

  localparam int unsigned DIST_W = dist_width(COORD_WIDTH);

  plane_t                   planes [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0] coord_a [AXES];
  logic signed [COORD_WIDTH-1:0] coord_b [AXES];
  logic                     mid_valid, mid_stall;
  logic signed [DIST_W-1:0] dist_a [PLANE_COUNT];
  logic signed [DIST_W-1:0] dist_b [PLANE_COUNT];
  logic [COORD_WIDTH-2:0]   mid_radius;

  assign coord_a[0] = start_x_i;
  assign coord_a[1] = start_y_i;
  assign coord_a[2] = start_z_i;
  assign coord_b[0] = end_x_i;
  assign coord_b[1] = end_y_i;
  assign coord_b[2] = end_z_i;

  // Plane registers
  cfc_regs #(
    .PLANE_COUNT(PLANE_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .planes_o(planes)
  );

  // Signed plane distances of both endpoints
  cfc_dist #(
    .PLANE_COUNT     (PLANE_COUNT),
    .COORD_WIDTH     (COORD_WIDTH),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS),
    .DIST_W          (DIST_W)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .planes_i (planes),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .coord_a_i(coord_a),
    .coord_b_i(coord_b),
    .radius_i (capsule_radius_i),
    .valid_o  (mid_valid),
    .stall_i  (mid_stall),
    .dist_a_o (dist_a),
    .dist_b_o (dist_b),
    .radius_o (mid_radius)
  );

  // Per-plane tests and final classification
  cfc_decide #(
    .PLANE_COUNT     (PLANE_COUNT),
    .COORD_WIDTH     (COORD_WIDTH),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS),
    .DIST_W          (DIST_W)
  ) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (mid_valid),
    .stall_o      (mid_stall),
    .dist_a_i     (dist_a),
    .dist_b_i     (dist_b),
    .radius_i     (mid_radius),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .containment_o(containment_o)
  );

endmodule

`default_nettype wire

>>> rtl/cfc_regs.sv
`default_nettype none

module cfc_regs #(
  parameter int unsigned PLANE_COUNT = cfc_pkg::PLANE_COUNT_DEF,
  parameter int unsigned ADDR_W      = cfc_pkg::idx_width(PLANE_COUNT) + 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ADDR_W-1:0]           paddr,
  input  wire logic [cfc_pkg::PLANE_W-1:0] pwdata,
  output logic      [cfc_pkg::PLANE_W-1:0] prdata,
  output logic                             pready,
  output cfc_pkg::plane_t                  planes_o [PLANE_COUNT]
);
  import cfc_pkg::*;

  localparam int unsigned IDX_W = ADDR_W - 3;

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             wr_en;
  plane_t           planes_q [PLANE_COUNT];

  // Decode the 8-byte register slot
  assign idx      = paddr[ADDR_W-1:3];
  assign in_range = (32'(idx) < PLANE_COUNT);
  assign wr_en    = psel & penable & pwrite;
  assign pready   = 1'b1;

  // Store plane registers; drop writes beyond the last plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en && in_range) begin
      planes_q[idx] <= plane_t'(pwdata);
    end
  end

  // Read back the addressed plane, zero outside the list
  always_comb begin
    prdata = '0;
    if (in_range) begin
      prdata = planes_q[idx];
    end
  end

  assign planes_o = planes_q;

`ifndef ASSERT_OFF
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && in_range) |=> (planes_q[$past(idx)] == $past(pwdata)))
    else $error("plane register write did not land");
`endif

endmodule

`default_nettype wire

>>> rtl/cfc_dist.sv
`default_nettype none

module cfc_dist #(
  parameter int unsigned PLANE_COUNT      = cfc_pkg::PLANE_COUNT_DEF,
  parameter int unsigned COORD_WIDTH      = cfc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = cfc_pkg::NORMAL_FRAC_DEF,
  parameter int unsigned DIST_W           = cfc_pkg::dist_width(COORD_WIDTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cfc_pkg::plane_t               planes_i   [PLANE_COUNT],
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] coord_a_i  [cfc_pkg::AXES],
  input  wire logic signed [COORD_WIDTH-1:0] coord_b_i  [cfc_pkg::AXES],
  input  wire logic        [COORD_WIDTH-2:0] radius_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic signed      [DIST_W-1:0]      dist_a_o   [PLANE_COUNT],
  output logic signed      [DIST_W-1:0]      dist_b_o   [PLANE_COUNT],
  output logic             [COORD_WIDTH-2:0] radius_o
);
  import cfc_pkg::*;

  localparam int unsigned PROD_W = NORM_W + COORD_WIDTH;

  logic signed [NORM_W-1:0] nrm [PLANE_COUNT][AXES];

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  logic signed [PROD_W-1:0] pa_q [PLANE_COUNT][AXES];
  logic signed [PROD_W-1:0] pb_q [PLANE_COUNT][AXES];
  logic [COORD_WIDTH-2:0]   r1_q, r2_q;
  logic signed [DIST_W-1:0] da_q [PLANE_COUNT];
  logic signed [DIST_W-1:0] db_q [PLANE_COUNT];
  logic signed [DIST_W-1:0] dsc  [PLANE_COUNT];

  // Spread normals into per-axis lanes and scale the offsets
  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      nrm[i][0] = planes_i[i].nx;
      nrm[i][1] = planes_i[i].ny;
      nrm[i][2] = planes_i[i].nz;
      dsc[i]    = DIST_W'(planes_i[i].d) <<< NORMAL_FRAC_BITS;
    end
  end

  // Advance a stage when it is empty or the next one takes its beat
  assign en2     = !v2_q || !stall_i;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  // Stage 1: products of normal and coordinate, one multiplier per lane and endpoint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        for (int k = 0; k < AXES; k++) begin
          pa_q[i][k] <= PROD_W'(nrm[i][k]) * PROD_W'(coord_a_i[k]);
          pb_q[i][k] <= PROD_W'(nrm[i][k]) * PROD_W'(coord_b_i[k]);
        end
      end
      r1_q <= radius_i;
    end
  end

  // Stage 2: sum the three products and the scaled offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        da_q[i] <= DIST_W'(pa_q[i][0]) + DIST_W'(pa_q[i][1])
                 + DIST_W'(pa_q[i][2]) + dsc[i];
        db_q[i] <= DIST_W'(pb_q[i][0]) + DIST_W'(pb_q[i][1])
                 + DIST_W'(pb_q[i][2]) + dsc[i];
      end
      r2_q <= r1_q;
    end
  end

  assign valid_o  = v2_q;
  assign dist_a_o = da_q;
  assign dist_b_o = db_q;
  assign radius_o = r2_q;

`ifndef ASSERT_OFF
  a_stage1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("beat lost between product and sum stages");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && stall_i))
    else $error("input stalled while the distance stages have room");
`endif

endmodule

`default_nettype wire

>>> rtl/cfc_decide.sv
`default_nettype none

module cfc_decide #(
  parameter int unsigned PLANE_COUNT      = cfc_pkg::PLANE_COUNT_DEF,
  parameter int unsigned COORD_WIDTH      = cfc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = cfc_pkg::NORMAL_FRAC_DEF,
  parameter int unsigned DIST_W           = cfc_pkg::dist_width(COORD_WIDTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic signed [DIST_W-1:0]      dist_a_i [PLANE_COUNT],
  input  wire logic signed [DIST_W-1:0]      dist_b_i [PLANE_COUNT],
  input  wire logic        [COORD_WIDTH-2:0] radius_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic             [1:0]             containment_o
);
  import cfc_pkg::*;

  logic signed [DIST_W-1:0] r_sc, neg_r;
  logic                     v3_q, v4_q;
  logic                     en3, en4;
  logic [PLANE_COUNT-1:0]   far_q;
  logic [PLANE_COUNT-1:0]   near_q;
  cls_e                     cls_q;

  // Scale the radius to the distance format
  assign r_sc  = DIST_W'(radius_i) <<< NORMAL_FRAC_BITS;
  assign neg_r = -r_sc;

  assign en4     = !v4_q || !stall_i;
  assign en3     = !v3_q || en4;
  assign stall_o = !en3;

  // Stage 3: per-plane tests, both endpoints outside or either one too close
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        far_q[i]  <= (dist_a_i[i] < neg_r) && (dist_b_i[i] < neg_r);
        near_q[i] <= (dist_a_i[i] < r_sc) || (dist_b_i[i] < r_sc);
      end
    end
  end

  // Stage 4: merge planes; any plane fully outside wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      priority if (|far_q) begin
        cls_q <= CLS_DISJOINT;
      end else if (|near_q) begin
        cls_q <= CLS_INTERSECTS;
      end else begin
        cls_q <= CLS_CONTAINED;
      end
    end
  end

  assign valid_o       = v4_q;
  assign containment_o = cls_q;

`ifndef ASSERT_OFF
  a_far_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && (|far_q)) |=> (cls_q == CLS_DISJOINT))
    else $error("plane fully outside did not give disjoint");

  a_contained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && !(|far_q) && !(|near_q)) |=> (cls_q == CLS_CONTAINED))
    else $error("clear of every plane but not contained");
`endif

endmodule

`default_nettype wire
